// ===== rtl/core/fcsg_pkg.sv =====
// Shared types, constants and bus layouts of the filled circle span generator.
`default_nettype none
package fcsg_pkg;

   localparam int MAX_DIM_DEFAULT    = 4096;
   localparam int MAX_RADIUS_DEFAULT = 4095;

   localparam int COORD_W  = 14;
   localparam int RUN_W    = 12;
   localparam int DEC_W    = 16;
   localparam int PIX_W    = 12;
   localparam int COLOR_W  = 8;
   localparam int DIM_W    = 13;
   localparam int CALC_W   = 16;
   localparam int NUM_SLOT = 6;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;
   localparam logic [DIM_W-1:0] DIM_RESET = 13'd4096;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_USER_W = 2;

   localparam int RSP_ROW_LSB   = 0;
   localparam int RSP_FIRST_LSB = 12;
   localparam int RSP_LAST_LSB  = 24;
   localparam int RSP_RED_LSB   = 36;
   localparam int RSP_GREEN_LSB = 44;
   localparam int RSP_BLUE_LSB  = 52;
   localparam int RSP_PAD_LSB   = 60;

   localparam int USER_INVERT   = 0;
   localparam int USER_FINISHED = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INVERT_MODE  = 3'd0,
      CSR_FILL_RED     = 3'd1,
      CSR_FILL_GREEN   = 3'd2,
      CSR_FILL_BLUE    = 3'd3,
      CSR_IMAGE_WIDTH  = 3'd4,
      CSR_IMAGE_HEIGHT = 3'd5
   } csr_index_type;

   typedef enum logic {
      ACTION_LOAD = 1'b0,
      ACTION_STEP = 1'b1
   } action_type;

   typedef struct packed {
      logic [PIX_W-1:0] row;
      logic [PIX_W-1:0] x_first;
      logic [PIX_W-1:0] x_last;
   } span_type;

endpackage
`default_nettype wire

// ===== rtl/core/filled_circle_span_generator.sv =====
// Top level of the filled circle span generator: midpoint state, span slots and output register.
`default_nettype none
// A load transaction (tuser low) latches a centre and a radius and produces no output; a step
// transaction (tuser high) advances the midpoint circle by one row pair and produces up to six
// clipped horizontal spans, one rsp transaction per cycle while rsp_tready allows, the last of the
// step with tlast. A step holds the block until its surviving spans have moved out; loads and steps
// whose spans are all clipped away do not hold it. The limit is the single span the output
// register can take each cycle; the next request is taken in the cycle its last span moves out.
module filled_circle_span_generator
   import fcsg_pkg::*;
#(
   parameter int MAX_DIM    = MAX_DIM_DEFAULT,
   parameter int MAX_RADIUS = MAX_RADIUS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // center_x[13:0], center_y[27:14], radius[39:28]
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   // action[0]
   input  wire logic                   req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // row[11:0], x_first[23:12], x_last[35:24], color_red[43:36], color_green[51:44],
   // color_blue[59:52], zero[63:60]
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   output logic                        rsp_tlast,
   // invert[0], finished[1]
   output logic [RSP_USER_W-1:0]       rsp_tuser,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic                 invert_ff, invert_in;
   logic [COLOR_W-1:0]   red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic [DIM_W-1:0]     width_ff, width_in, height_ff, height_in;

   logic signed [COORD_W-1:0] ccol_ff, ccol_in, crow_ff, crow_in;
   logic [RUN_W-1:0]          runx_ff, runx_in, runy_ff, runy_in;
   logic [DEC_W-1:0]          dec_ff, dec_in;
   logic                      stepped_ff, stepped_in, active_ff, active_in;

   logic signed [COORD_W-1:0] snap_col_ff, snap_col_in, snap_row_ff, snap_row_in;
   logic [RUN_W-1:0]          snap_x_ff, snap_x_in, snap_y_ff, snap_y_in;
   logic                      snap_stepped_ff, snap_stepped_in, snap_fin_ff, snap_fin_in;
   logic [NUM_SLOT-1:0]       pend_ff, pend_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   span_type             rsp_span_ff, rsp_span_in;
   logic                 rsp_last_ff, rsp_last_in, rsp_fin_ff, rsp_fin_in;
   logic                 rsp_inv_ff, rsp_inv_in;
   logic [COLOR_W-1:0]   rsp_red_ff, rsp_red_in, rsp_green_ff, rsp_green_in;
   logic [COLOR_W-1:0]   rsp_blue_ff, rsp_blue_in;

   logic                      req_accept;
   action_type                req_action;
   logic signed [COORD_W-1:0] req_cx, req_cy;
   logic [RUN_W-1:0]          req_radius, radius_lim;

   logic                      dec_pos;
   logic signed [COORD_W-1:0] nx;
   logic [RUN_W:0]            ny;
   logic signed [DEC_W-1:0]   nx_w;
   logic [DEC_W-1:0]          ny_w;

   logic signed [CALC_W-1:0] cx, cy, xv, yv, wlim, hlim;
   logic signed [CALC_W-1:0] cand_row [NUM_SLOT];
   logic signed [CALC_W-1:0] cand_a   [NUM_SLOT];
   logic signed [CALC_W-1:0] cand_b   [NUM_SLOT];
   logic signed [CALC_W-1:0] clip_a   [NUM_SLOT];
   logic signed [CALC_W-1:0] clip_b   [NUM_SLOT];
   logic [NUM_SLOT-1:0]      cand_en, keep, eff, sel_oh, rest;
   span_type                 sel_span;
   logic                     out_free, move;

   assign req_action = action_type'(req_tuser);
   assign req_cx     = req_tdata[13:0];
   assign req_cy     = req_tdata[27:14];
   assign req_radius = req_tdata[39:28];
   assign radius_lim = (int'(req_radius) > MAX_RADIUS) ? RUN_W'(MAX_RADIUS) : req_radius;

   // Configuration registers.
   always_comb begin
      invert_in = invert_ff;
      red_in    = red_ff;
      green_in  = green_ff;
      blue_in   = blue_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_INVERT_MODE:  invert_in = csr_wdata[0];
            CSR_FILL_RED:     red_in    = csr_wdata[COLOR_W-1:0];
            CSR_FILL_GREEN:   green_in  = csr_wdata[COLOR_W-1:0];
            CSR_FILL_BLUE:    blue_in   = csr_wdata[COLOR_W-1:0];
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: height_in = csr_wdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // Midpoint loop update.
   assign dec_pos = $signed(dec_ff) > 0;
   assign nx   = dec_pos ? (COORD_W'(runx_ff) - COORD_W'(1)) : COORD_W'(runx_ff);
   assign ny   = (RUN_W+1)'(runy_ff) + (RUN_W+1)'(1);
   assign nx_w = DEC_W'(nx);
   assign ny_w = DEC_W'(ny);

   always_comb begin
      ccol_in         = ccol_ff;
      crow_in         = crow_ff;
      runx_in         = runx_ff;
      runy_in         = runy_ff;
      dec_in          = dec_ff;
      stepped_in      = stepped_ff;
      active_in       = active_ff;
      snap_col_in     = snap_col_ff;
      snap_row_in     = snap_row_ff;
      snap_x_in       = snap_x_ff;
      snap_y_in       = snap_y_ff;
      snap_stepped_in = snap_stepped_ff;
      snap_fin_in     = snap_fin_ff;
      if (req_accept) begin
         if (req_action == ACTION_LOAD) begin
            ccol_in    = req_cx;
            crow_in    = req_cy;
            runx_in    = radius_lim;
            runy_in    = '0;
            dec_in     = DEC_W'(3) - {{(DEC_W-RUN_W-1){1'b0}}, radius_lim, 1'b0};
            stepped_in = 1'b0;
            active_in  = 1'b1;
         end else if (active_ff) begin
            snap_col_in     = ccol_ff;
            snap_row_in     = crow_ff;
            snap_x_in       = runx_ff;
            snap_y_in       = runy_ff;
            snap_stepped_in = stepped_ff;
            if (dec_pos) begin
               stepped_in = 1'b1;
               dec_in     = dec_ff + DEC_W'(10) - (nx_w <<< 2) + (ny_w << 2);
            end else begin
               stepped_in = 1'b0;
               dec_in     = dec_ff + DEC_W'(6) + (ny_w << 2);
            end
            active_in   = nx >= $signed({1'b0, ny});
            snap_fin_in = !(nx >= $signed({1'b0, ny}));
            runx_in     = nx[RUN_W-1:0];
            runy_in     = ny[RUN_W-1:0];
         end
      end
   end

   // Candidate spans of the captured pass, in emission order.
   assign cx   = CALC_W'(snap_col_ff);
   assign cy   = CALC_W'(snap_row_ff);
   assign xv   = $signed({{(CALC_W-RUN_W){1'b0}}, snap_x_ff});
   assign yv   = $signed({{(CALC_W-RUN_W){1'b0}}, snap_y_ff});
   assign wlim = (int'(width_ff) > MAX_DIM) ? CALC_W'(MAX_DIM) : CALC_W'(width_ff);
   assign hlim = (int'(height_ff) > MAX_DIM) ? CALC_W'(MAX_DIM) : CALC_W'(height_ff);

   always_comb begin
      for (int i = 0; i < NUM_SLOT; i++) begin
         cand_row[i] = cy;
         cand_a[i]   = cx;
         cand_b[i]   = cx;
      end
      cand_en = '0;
      if (snap_y_ff == '0) begin
         cand_en     = 6'b000111;
         cand_a[0]   = cx - xv;
         cand_b[0]   = cx + xv;
         cand_row[1] = cy + xv;
         cand_row[2] = cy - xv;
      end else begin
         cand_en     = 6'b000011;
         cand_row[0] = cy + yv;
         cand_row[1] = cy - yv;
         cand_a[0]   = cx - xv;
         cand_b[0]   = cx + xv;
         cand_a[1]   = cx - xv;
         cand_b[1]   = cx + xv;
         if (snap_x_ff != snap_y_ff) begin
            if (!snap_stepped_ff) begin
               cand_en     = 6'b111111;
               cand_row[2] = cy + xv;
               cand_row[3] = cy + xv;
               cand_row[4] = cy - xv;
               cand_row[5] = cy - xv;
               cand_a[2]   = cx + yv;
               cand_b[2]   = cx + yv;
               cand_a[3]   = cx - yv;
               cand_b[3]   = cx - yv;
               cand_a[4]   = cx + yv;
               cand_b[4]   = cx + yv;
               cand_a[5]   = cx - yv;
               cand_b[5]   = cx - yv;
            end else begin
               cand_en     = 6'b001111;
               cand_row[2] = cy + xv;
               cand_row[3] = cy - xv;
               cand_a[2]   = cx - yv;
               cand_b[2]   = cx + yv;
               cand_a[3]   = cx - yv;
               cand_b[3]   = cx + yv;
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_SLOT; i++) begin
         clip_a[i] = (cand_a[i] < 0) ? '0 : cand_a[i];
         clip_b[i] = (cand_b[i] > wlim - CALC_W'(1)) ? wlim - CALC_W'(1) : cand_b[i];
         keep[i]   = cand_en[i] && (cand_row[i] >= 0) && (cand_row[i] < hlim)
                     && (clip_a[i] <= clip_b[i]);
      end
   end

   // Lowest pending slot goes out next.
   assign eff    = pend_ff & keep;
   assign sel_oh = eff & (~eff + NUM_SLOT'(1));
   assign rest   = eff & ~sel_oh;

   always_comb begin
      sel_span = '0;
      for (int i = 0; i < NUM_SLOT; i++) begin
         if (sel_oh[i]) begin
            sel_span.row     = cand_row[i][PIX_W-1:0];
            sel_span.x_first = clip_a[i][PIX_W-1:0];
            sel_span.x_last  = clip_b[i][PIX_W-1:0];
         end
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign move       = (eff != '0) && out_free;
   assign req_tready = ((move ? rest : eff) == '0);
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      pend_in = move ? rest : eff;
      if (req_accept) begin
         pend_in = (req_action == ACTION_STEP && active_ff) ? '1 : '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_span_in  = rsp_span_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_fin_in   = rsp_fin_ff;
      rsp_inv_in   = rsp_inv_ff;
      rsp_red_in   = rsp_red_ff;
      rsp_green_in = rsp_green_ff;
      rsp_blue_in  = rsp_blue_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
         rsp_span_in  = sel_span;
         rsp_last_in  = (rest == '0);
         rsp_fin_in   = (rest == '0) && snap_fin_ff;
         rsp_inv_in   = invert_ff;
         rsp_red_in   = invert_ff ? '0 : red_ff;
         rsp_green_in = invert_ff ? '0 : green_ff;
         rsp_blue_in  = invert_ff ? '0 : blue_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff    <= 1'b0;
         red_ff       <= '0;
         green_ff     <= '0;
         blue_ff      <= '0;
         width_ff     <= DIM_RESET;
         height_ff    <= DIM_RESET;
         ccol_ff      <= '0;
         crow_ff      <= '0;
         runx_ff      <= '0;
         runy_ff      <= '0;
         dec_ff       <= '0;
         stepped_ff   <= 1'b0;
         active_ff    <= 1'b0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         invert_ff    <= invert_in;
         red_ff       <= red_in;
         green_ff     <= green_in;
         blue_ff      <= blue_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         ccol_ff      <= ccol_in;
         crow_ff      <= crow_in;
         runx_ff      <= runx_in;
         runy_ff      <= runy_in;
         dec_ff       <= dec_in;
         stepped_ff   <= stepped_in;
         active_ff    <= active_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_col_ff     <= snap_col_in;
      snap_row_ff     <= snap_row_in;
      snap_x_ff       <= snap_x_in;
      snap_y_ff       <= snap_y_in;
      snap_stepped_ff <= snap_stepped_in;
      snap_fin_ff     <= snap_fin_in;
      rsp_span_ff     <= rsp_span_in;
      rsp_last_ff     <= rsp_last_in;
      rsp_fin_ff      <= rsp_fin_in;
      rsp_inv_ff      <= rsp_inv_in;
      rsp_red_ff      <= rsp_red_in;
      rsp_green_ff    <= rsp_green_in;
      rsp_blue_ff     <= rsp_blue_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_fin_ff, rsp_inv_ff};
   assign rsp_tdata  = {{(RSP_DATA_W-RSP_PAD_LSB){1'b0}}, rsp_blue_ff, rsp_green_ff,
                        rsp_red_ff, rsp_span_ff.x_last, rsp_span_ff.x_first,
                        rsp_span_ff.row};

endmodule
`default_nettype wire

// ===== rtl/core/fcsg_checker.sv =====
// Port-level checks of the filled circle span generator and their bind statement.
`default_nettype none
module fcsg_checker
   import fcsg_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tlast,
   input wire logic [RSP_USER_W-1:0] rsp_tuser
);

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Result transaction shown right after reset.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("Stalled result transaction changed.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_FIRST_LSB +: PIX_W] <= rsp_tdata[RSP_LAST_LSB +: PIX_W])
      else $error("Span ends before it starts.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[USER_FINISHED] |-> rsp_tlast)
      else $error("Finished mark on a span that is not the last of its step.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[USER_INVERT] |->
         rsp_tdata[RSP_RED_LSB +: 3 * COLOR_W] == '0)
      else $error("Invert span carries a nonzero color.");

endmodule

bind filled_circle_span_generator fcsg_checker u_fcsg_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

// ===== verif/filled_circle_span_generator_tb.sv =====
// Self-checking testbench of the filled circle span generator, with a span scoreboard class.
module filled_circle_span_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fcsg_pkg::*;

   localparam int HOLDOFF_CYCLES = 300;
   localparam int SETTLE_CYCLES  = 8;
   localparam int QUIET_LIMIT    = 3000;
   localparam int RANDOM_ITEMS   = 15;

   typedef struct packed {
      span_type         geom;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic             invert;
      logic             last;
      logic             finished;
   } span_expect_type;

   class circle_span_scoreboard;
      bit                   invert_mode;
      bit [COLOR_W-1:0]     fill_red, fill_green, fill_blue;
      bit [DIM_W-1:0]       image_width, image_height;
      int                   centre_col, centre_row;
      bit [RUN_W-1:0]       run_x, run_y;
      bit signed [DEC_W-1:0] decision;
      bit                   stepped_x, circle_active;
      span_expect_type      pending_spans[$];
      span_expect_type      step_spans[$];
      int                   errors, spans_checked, circles_done, loads_seen, steps_seen;

      function new();
         invert_mode = 1'b0;
         fill_red = '0;
         fill_green = '0;
         fill_blue = '0;
         image_width = DIM_RESET;
         image_height = DIM_RESET;
         centre_col = 0;
         centre_row = 0;
         run_x = '0;
         run_y = '0;
         decision = '0;
         stepped_x = 1'b0;
         circle_active = 1'b0;
         errors = 0;
         spans_checked = 0;
         circles_done = 0;
         loads_seen = 0;
         steps_seen = 0;
      endfunction

      function void write_reg(csr_index_type idx, bit [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_INVERT_MODE:  invert_mode = value[0];
            CSR_FILL_RED:     fill_red = value[COLOR_W-1:0];
            CSR_FILL_GREEN:   fill_green = value[COLOR_W-1:0];
            CSR_FILL_BLUE:    fill_blue = value[COLOR_W-1:0];
            CSR_IMAGE_WIDTH:  image_width = value[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: image_height = value[DIM_W-1:0];
            default: ;
         endcase
      endfunction

      function void clip_span(int row, int col_a, int col_b);
         int              w, h;
         span_expect_type s;
         w = (image_width > MAX_DIM_DEFAULT) ? MAX_DIM_DEFAULT : int'(image_width);
         h = (image_height > MAX_DIM_DEFAULT) ? MAX_DIM_DEFAULT : int'(image_height);
         if (row < 0 || row >= h) return;
         if (col_a < 0) col_a = 0;
         if (col_b > w - 1) col_b = w - 1;
         if (col_a > col_b) return;
         s.geom.row = PIX_W'(row);
         s.geom.x_first = PIX_W'(col_a);
         s.geom.x_last = PIX_W'(col_b);
         s.invert = invert_mode;
         s.red = invert_mode ? '0 : fill_red;
         s.green = invert_mode ? '0 : fill_green;
         s.blue = invert_mode ? '0 : fill_blue;
         s.last = 1'b0;
         s.finished = 1'b0;
         step_spans.push_back(s);
      endfunction

      function void note_request(action_type act, bit signed [COORD_W-1:0] cx,
                                 bit signed [COORD_W-1:0] cy, bit [RUN_W-1:0] radius);
         int x, y, nx, ny, d;
         if (act == ACTION_LOAD) begin
            loads_seen++;
            centre_col = cx;
            centre_row = cy;
            run_x = radius;
            run_y = '0;
            decision = DEC_W'(3 - 2 * int'(radius));
            stepped_x = 1'b0;
            circle_active = 1'b1;
            return;
         end
         steps_seen++;
         if (!circle_active) return;
         x = run_x;
         y = run_y;
         step_spans.delete();
         if (y == 0) begin
            clip_span(centre_row, centre_col - x, centre_col + x);
            clip_span(centre_row + x, centre_col, centre_col);
            clip_span(centre_row - x, centre_col, centre_col);
         end else begin
            clip_span(centre_row + y, centre_col - x, centre_col + x);
            clip_span(centre_row - y, centre_col - x, centre_col + x);
            if (x != y) begin
               if (!stepped_x) begin
                  clip_span(centre_row + x, centre_col + y, centre_col + y);
                  clip_span(centre_row + x, centre_col - y, centre_col - y);
                  clip_span(centre_row - x, centre_col + y, centre_col + y);
                  clip_span(centre_row - x, centre_col - y, centre_col - y);
               end else begin
                  clip_span(centre_row + x, centre_col - y, centre_col + y);
                  clip_span(centre_row - x, centre_col - y, centre_col + y);
               end
            end
         end
         ny = y + 1;
         nx = x;
         d = decision;
         if (d > 0) begin
            stepped_x = 1'b1;
            nx = x - 1;
            d = d + 2 * (5 - 2 * nx + 2 * ny);
         end else begin
            stepped_x = 1'b0;
            d = d + 2 * (3 + 2 * ny);
         end
         decision = DEC_W'(d);
         circle_active = (nx >= ny);
         run_x = RUN_W'(nx);
         run_y = RUN_W'(ny);
         if (!circle_active) circles_done++;
         if (step_spans.size() > 0) begin
            step_spans[step_spans.size() - 1].last = 1'b1;
            step_spans[step_spans.size() - 1].finished = !circle_active;
         end
         foreach (step_spans[i]) pending_spans.push_back(step_spans[i]);
      endfunction

      function string span_text(span_expect_type s);
         return $sformatf("row %0d cols %0d..%0d rgb %02h/%02h/%02h inv %0b last %0b fin %0b",
                          s.geom.row, s.geom.x_first, s.geom.x_last, s.red, s.green, s.blue,
                          s.invert, s.last, s.finished);
      endfunction

      function void check_span(logic [RSP_DATA_W-1:0] tdata, logic tlast,
                               logic [RSP_USER_W-1:0] tuser);
         span_expect_type                       want, got;
         logic [RSP_DATA_W-RSP_PAD_LSB-1:0]     pad;
         got.geom.row = tdata[RSP_ROW_LSB +: PIX_W];
         got.geom.x_first = tdata[RSP_FIRST_LSB +: PIX_W];
         got.geom.x_last = tdata[RSP_LAST_LSB +: PIX_W];
         got.red = tdata[RSP_RED_LSB +: COLOR_W];
         got.green = tdata[RSP_GREEN_LSB +: COLOR_W];
         got.blue = tdata[RSP_BLUE_LSB +: COLOR_W];
         got.invert = tuser[USER_INVERT];
         got.finished = tuser[USER_FINISHED];
         got.last = tlast;
         pad = tdata[RSP_DATA_W-1:RSP_PAD_LSB];
         if (pending_spans.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Unexpected span at %0t: %s", $realtime, span_text(got));
            return;
         end
         want = pending_spans.pop_front();
         spans_checked++;
         if (got !== want || pad !== '0) begin
            errors++;
            if (errors <= 10) begin
               $display("Span mismatch at %0t:", $realtime);
               $display("   expected %s", span_text(want));
               $display("   actual   %s pad %0h", span_text(got), pad);
            end
         end
      endfunction

      function void check_leftovers();
         if (pending_spans.size() > 0) begin
            errors += pending_spans.size();
            $display("%0d expected spans never arrived", pending_spans.size());
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;
   logic [RSP_USER_W-1:0]  rsp_tuser;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   circle_span_scoreboard sb = new;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  holdoff_pending = 1'b0;
   int  items_sent = 0;
   int  configs_applied = 0;

   filled_circle_span_generator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_span(rsp_tdata, rsp_tlast, rsp_tuser);
   end

   initial begin : receiver
      forever begin
         @(posedge clock);
         if (holdoff_pending) begin
            holdoff_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic send_item(action_type act, logic signed [COORD_W-1:0] cx,
                            logic signed [COORD_W-1:0] cy, logic [RUN_W-1:0] radius);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {radius, cy, cx};
      do @(posedge clock); while (!req_tready);
      sb.note_request(act, cx, cy, radius);
      items_sent++;
   endtask

   task automatic send_step();
      send_item(ACTION_STEP, COORD_W'($urandom), COORD_W'($urandom), RUN_W'($urandom));
   endtask

   task automatic run_circle(int cx, int cy, int radius, int max_steps);
      int n;
      n = 0;
      send_item(ACTION_LOAD, COORD_W'(cx), COORD_W'(cy), RUN_W'(radius));
      while (sb.circle_active && n < max_steps) begin
         send_step();
         n++;
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending_spans.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, int value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      sb.write_reg(idx, CSR_DATA_W'(value));
      @(posedge clock);
   endtask

   task automatic apply_config(int inv, int red, int green, int blue, int w, int h);
      write_csr(CSR_INVERT_MODE, inv);
      write_csr(CSR_FILL_RED, red);
      write_csr(CSR_FILL_GREEN, green);
      write_csr(CSR_FILL_BLUE, blue);
      write_csr(CSR_IMAGE_WIDTH, w);
      write_csr(CSR_IMAGE_HEIGHT, h);
      csr_we <= 1'b0;
      configs_applied++;
   endtask

   function automatic int pick_dim();
      case ($urandom_range(3))
         0: return $urandom_range(64, 1);
         1: return MAX_DIM_DEFAULT;
         2: return $urandom_range(8191, 1);
         default: return $urandom_range(48, 16);
      endcase
   endfunction

   function automatic int near_coord(int dim);
      int lim;
      lim = (dim > 200) ? 200 : dim;
      return int'($urandom_range(lim + 16)) - 8;
   endfunction

   task automatic run_random(int n_items);
      int start, k;
      start = items_sent;
      while (items_sent - start < n_items) begin
         k = $urandom_range(99);
         if (k < 70) begin
            run_circle(near_coord(sb.image_width), near_coord(sb.image_height),
                       $urandom_range(24), 1 << 20);
         end else if (k < 85) begin
            run_circle(int'($urandom_range(16383)) - 8192, int'($urandom_range(16383)) - 8192,
                       $urandom_range(4095), $urandom_range(4, 1));
         end else if (k < 93) begin
            send_step();
         end else begin
            send_item(ACTION_LOAD, COORD_W'($urandom), COORD_W'($urandom), RUN_W'($urandom));
         end
      end
   endtask

   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      apply_config(0, 8'hFF, 8'h00, 8'hAA, 4096, 4096);
      send_step();
      run_circle(5, 5, 0, 1 << 20);
      send_step();
      run_circle(10, 10, 3, 1 << 20);
      run_circle(-8192, -8192, 4095, 1);
      run_circle(8191, 8191, 4095, 1);
      run_circle(0, 0, 4095, 2);
      run_circle(4095, 4095, 4095, 1);
      run_circle(-1, 20, 1, 1 << 20);
      wait_idle();

      apply_config(1, 8'h5A, 8'hA5, 8'hFF, 8191, 8191);
      run_circle(4094, 4094, 2, 1 << 20);
      wait_idle();
      apply_config(0, 8'h00, 8'hFF, 8'h00, 1, 1);
      run_circle(0, 0, 1, 1 << 20);
      wait_idle();
      apply_config(0, 8'h12, 8'h34, 8'h56, 0, 0);
      run_circle(1, 1, 2, 1 << 20);

      for (int phase = 0; phase < 4; phase++) begin
         wait_idle();
         apply_config($urandom_range(1), $urandom_range(255), $urandom_range(255),
                      $urandom_range(255), pick_dim(), pick_dim());
         send_idle_pct = (phase == 1) ? 78 : (phase == 3) ? 18 : 0;
         recv_stall_pct = (phase == 2) ? 78 : (phase == 3) ? 18 : 0;
         if (phase == 0) holdoff_pending = 1'b1;
         run_random(RANDOM_ITEMS);
      end
      wait_idle();
      sb.check_leftovers();

      $display("Run covered %0d transactions (%0d loads, %0d steps) and checked %0d spans,",
               items_sent, sb.loads_seen, sb.steps_seen, sb.spans_checked);
      $display("finishing %0d circles under %0d register settings and four idling patterns.",
               sb.circles_done, configs_applied);
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d failures", sb.errors);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/fcsg_pkg.sv
rtl/core/filled_circle_span_generator.sv
rtl/core/fcsg_checker.sv
verif/filled_circle_span_generator_tb.sv
